/* design/pnes_pkg.sv */
`default_nettype none
package pnes_pkg;

   localparam int ID_W     = 32;
   localparam int CPOS_W   = 48;
   localparam int DUR_W    = 14;
   localparam int OFS_W    = 13;
   localparam int WORD_W   = 32;
   localparam int PERIOD_W = 24;

   localparam logic [WORD_W-1:0]   WORD_NOTE_ON  = 32'h20903c7f;
   localparam logic [WORD_W-1:0]   WORD_NOTE_OFF = 32'h20803c7f;
   localparam logic [DUR_W-1:0]    DURATION_MAX  = 14'd8192;
   localparam logic [PERIOD_W-1:0] PERIOD_RESET  = 24'd6000;
   localparam logic [ID_W-1:0]     CLOCK_INVALID = 32'hFFFF_FFFF;

   // divider status back to the sequencer
   typedef struct packed {
      logic                done;
      logic                q_lsb;
      logic [PERIOD_W-1:0] rem;
   } div_result_type;

   // first boundary handed to the emitter
   typedef struct packed {
      logic             start;
      logic [OFS_W-1:0] off;
      logic             parity;
      logic [DUR_W-1:0] dur;
   } emit_start_type;

endpackage
`default_nettype wire

/* design/pnes_if.sv */
`default_nettype none
interface pnes_req_if;
   logic                        valid;
   logic                        ready;
   logic                        action;
   logic [pnes_pkg::ID_W-1:0]   timebase_id;
   logic [pnes_pkg::CPOS_W-1:0] clock_position;
   logic [pnes_pkg::DUR_W-1:0]  cycle_duration;

   modport source (output valid, action, timebase_id, clock_position, cycle_duration,
                   input ready);
   modport sink (input valid, action, timebase_id, clock_position, cycle_duration,
                 output ready);
endinterface

interface pnes_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [pnes_pkg::OFS_W-1:0]  event_offset;
   logic                        note_on;
   logic [pnes_pkg::WORD_W-1:0] event_word;
   logic                        last_event;
   logic                        events_dropped;

   modport source (output valid, event_offset, note_on, event_word, last_event,
                   events_dropped, input ready);
   modport sink (input valid, event_offset, note_on, event_word, last_event,
                 events_dropped, output ready);
endinterface

interface pnes_csr_if;
   logic                          valid;
   logic                          ready;
   logic [pnes_pkg::PERIOD_W-1:0] period_samples;

   modport source (output valid, period_samples, input ready);
   modport sink (input valid, period_samples, output ready);
endinterface
`default_nettype wire

/* design/pnes_divider.sv */
`default_nettype none
// Restoring divider, one quotient bit per cycle, MSB first.
// Only the remainder and the quotient LSB are kept.
module pnes_divider #(
   parameter int POSITION_BITS = 48
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [POSITION_BITS-1:0]      dividend,
   input  wire logic [pnes_pkg::PERIOD_W-1:0] divisor,
   output pnes_pkg::div_result_type           result
);
   import pnes_pkg::*;

   localparam int CNT_W = $clog2(POSITION_BITS + 1);

   logic [POSITION_BITS-1:0] dvd_ff, dvd_in;
   logic [PERIOD_W-1:0]      rem_ff, rem_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic                     q_ff, q_in;
   logic [PERIOD_W:0]        trial;
   logic                     ge;

   assign trial = {rem_ff, dvd_ff[POSITION_BITS-1]};
   assign ge    = trial >= {1'b0, divisor};

   always_comb begin
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      q_in    = q_ff;
      done_in = 1'b0;
      if (start) begin
         dvd_in  = dividend;
         rem_in  = '0;
         cnt_in  = CNT_W'(POSITION_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[POSITION_BITS-2:0], 1'b0};
         rem_in = ge ? PERIOD_W'(trial - {1'b0, divisor}) : trial[PERIOD_W-1:0];
         q_in   = ge;
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign result.done  = done_ff;
   assign result.q_lsb = q_ff;
   assign result.rem   = rem_ff;

   a_cnt_live: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff != '0)
      else $error("divider busy with zero count");

endmodule
`default_nettype wire

/* design/pnes_emitter.sv */
`default_nettype none
// Steps through period boundaries, one event per transfer slot.
module pnes_emitter #(
   parameter int MAX_EVENTS = 64
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire pnes_pkg::emit_start_type      start,
   input  wire logic [pnes_pkg::PERIOD_W-1:0] period,
   output logic                               busy,
   pnes_rsp_if.source                         rsp
);
   import pnes_pkg::*;

   localparam int CNT_W = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;

   logic                busy_ff, busy_in;
   logic [OFS_W-1:0]    off_ff, off_in;
   logic                par_ff, par_in;
   logic [DUR_W-1:0]    dur_ff, dur_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                vld_ff, vld_in;
   logic [OFS_W-1:0]    ofs_ff, ofs_in;
   logic                on_ff, on_in;
   logic                last_ff, last_in;
   logic                drop_ff, drop_in;
   logic [PERIOD_W:0]   next_off;
   logic                more, at_max, load;

   assign next_off = (PERIOD_W+1)'(off_ff) + (PERIOD_W+1)'(period);
   assign more     = next_off < (PERIOD_W+1)'(dur_ff);
   assign at_max   = cnt_ff == CNT_W'(MAX_EVENTS - 1);
   assign load     = busy_ff && (!vld_ff || rsp.ready);

   always_comb begin
      busy_in = busy_ff;
      off_in  = off_ff;
      par_in  = par_ff;
      dur_in  = dur_ff;
      cnt_in  = cnt_ff;
      vld_in  = vld_ff && !rsp.ready;
      ofs_in  = ofs_ff;
      on_in   = on_ff;
      last_in = last_ff;
      drop_in = drop_ff;
      if (start.start) begin
         busy_in = 1'b1;
         off_in  = start.off;
         par_in  = start.parity;
         dur_in  = start.dur;
         cnt_in  = '0;
      end else if (load) begin
         vld_in  = 1'b1;
         ofs_in  = off_ff;
         on_in   = !par_ff;
         last_in = !more || at_max;
         drop_in = more && at_max;
         off_in  = next_off[OFS_W-1:0];
         par_in  = !par_ff;
         cnt_in  = cnt_ff + CNT_W'(1);
         if (!more || at_max) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      off_ff  <= off_in;
      par_ff  <= par_in;
      dur_ff  <= dur_in;
      cnt_ff  <= cnt_in;
      ofs_ff  <= ofs_in;
      on_ff   <= on_in;
      last_ff <= last_in;
      drop_ff <= drop_in;
      if (reset) begin
         busy_ff <= 1'b0;
         vld_ff  <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         vld_ff  <= vld_in;
      end
   end

   assign busy               = busy_ff;
   assign rsp.valid          = vld_ff;
   assign rsp.event_offset   = ofs_ff;
   assign rsp.note_on        = on_ff;
   assign rsp.event_word     = on_ff ? WORD_NOTE_ON : WORD_NOTE_OFF;
   assign rsp.last_event     = last_ff;
   assign rsp.events_dropped = drop_ff;

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (load && !start.start && (!more || at_max)) |=> !busy_ff && vld_ff && last_ff)
      else $error("last event did not end the burst");

   a_drop_on_last: assert property (@(posedge clock) disable iff (reset)
      (vld_ff && drop_ff) |-> last_ff)
      else $error("drop flag on a non-last event");

endmodule
`default_nettype wire

/* design/periodic_note_event_scheduler_top.sv */
`default_nettype none
// Channel  Role    Transfer moves
// -------  ------  --------------------------------------------------------
// req      sink    action, timebase_id, clock_position, cycle_duration
// rsp      source  event_offset, note_on, event_word, last_event, events_dropped
// csr      sink    period_samples (always ready)
//
// A restart transfer is absorbed in its accept cycle. A graph cycle passes
// REBASE, LOCAL, ADVANCE, DIVIDE and SETUP before its first event (serial divider, one
// quotient bit a cycle), then one event per cycle while rsp keeps up.
// Synchronous active-high reset: period 6000, clock id invalid, timeline zero.
// rsp is a registered slot; a stalled sink holds the emitter, not the divider.
// req is taken only when the sequencer is idle.
module periodic_note_event_scheduler_top #(
   parameter int MAX_EVENTS    = 64,
   parameter int POSITION_BITS = 48
) (
   input  wire logic  clock,
   input  wire logic  reset,
   pnes_req_if.sink   req,
   pnes_rsp_if.source rsp,
   pnes_csr_if.sink   csr
);
   import pnes_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE    = 7'b0000001,
      ST_REBASE  = 7'b0000010,
      ST_LOCAL   = 7'b0000100,
      ST_ADVANCE = 7'b0001000,
      ST_DIVIDE  = 7'b0010000,
      ST_SETUP   = 7'b0100000,
      ST_EMIT    = 7'b1000000
   } state_type;

   state_type                state_ff, state_in;
   logic [PERIOD_W-1:0]      period_ff;
   logic [ID_W-1:0]          cur_clock_ff, cur_clock_in;
   logic [POSITION_BITS-1:0] offset_ff, offset_in;
   logic [POSITION_BITS-1:0] expected_ff, expected_in;
   logic [ID_W-1:0]          id_ff, id_in;
   logic [POSITION_BITS-1:0] cpos_ff, cpos_in;
   logic [DUR_W-1:0]         dur_ff, dur_in;
   logic [POSITION_BITS-1:0] sp_ff, sp_in;

   logic [PERIOD_W-1:0]      period_eff;
   logic                     div_start;
   div_result_type           div_res;
   emit_start_type           emit_go;
   logic                     emit_busy;
   logic [PERIOD_W-1:0]      first_off;
   logic                     rem_nz;
   logic                     req_xfer;

   // zero period behaves as one
   assign period_eff = (period_ff == '0) ? PERIOD_W'(1) : period_ff;
   assign csr.ready  = 1'b1;
   assign req.ready  = (state_ff == ST_IDLE);
   assign req_xfer   = req.valid && req.ready;

   // first boundary at or after the local position
   assign rem_nz    = div_res.rem != '0;
   assign first_off = rem_nz ? (period_eff - div_res.rem) : '0;

   always_comb begin
      state_in     = state_ff;
      cur_clock_in = cur_clock_ff;
      offset_in    = offset_ff;
      expected_in  = expected_ff;
      id_in        = id_ff;
      cpos_in      = cpos_ff;
      dur_in       = dur_ff;
      sp_in        = sp_ff;
      div_start    = 1'b0;
      emit_go      = '0;
      emit_go.off    = first_off[OFS_W-1:0];
      emit_go.parity = div_res.q_lsb ^ rem_nz;
      emit_go.dur    = dur_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (req.action) begin
                  cur_clock_in = CLOCK_INVALID;
                  offset_in    = '0;
                  expected_in  = '0;
               end else begin
                  id_in    = req.timebase_id;
                  cpos_in  = POSITION_BITS'(req.clock_position);
                  dur_in   = (req.cycle_duration > DURATION_MAX) ? DURATION_MAX
                                                                 : req.cycle_duration;
                  state_in = ST_REBASE;
               end
            end
         end
         ST_REBASE: begin
            // new clock: keep the local timeline continuous
            if (cur_clock_ff != id_ff) begin
               offset_in    = cpos_ff - expected_ff;
               cur_clock_in = id_ff;
            end
            state_in = ST_LOCAL;
         end
         ST_LOCAL: begin
            sp_in    = cpos_ff - offset_ff;
            state_in = ST_ADVANCE;
         end
         ST_ADVANCE: begin
            expected_in = sp_ff + POSITION_BITS'(dur_ff);
            div_start   = 1'b1;
            state_in    = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (div_res.done) state_in = ST_SETUP;
         end
         ST_SETUP: begin
            if (first_off < PERIOD_W'(dur_ff)) begin
               emit_go.start = 1'b1;
               state_in      = ST_EMIT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (!emit_busy) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      id_ff   <= id_in;
      cpos_ff <= cpos_in;
      dur_ff  <= dur_in;
      sp_ff   <= sp_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         period_ff    <= PERIOD_RESET;
         cur_clock_ff <= CLOCK_INVALID;
         offset_ff    <= '0;
         expected_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         cur_clock_ff <= cur_clock_in;
         offset_ff    <= offset_in;
         expected_ff  <= expected_in;
         if (csr.valid && csr.ready) period_ff <= csr.period_samples;
      end
   end

   pnes_divider #(
      .POSITION_BITS (POSITION_BITS)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sp_ff),
      .divisor  (period_eff),
      .result   (div_res)
   );

   pnes_emitter #(
      .MAX_EVENTS (MAX_EVENTS)
   ) u_emitter (
      .clock  (clock),
      .reset  (reset),
      .start  (emit_go),
      .period (period_eff),
      .busy   (emit_busy),
      .rsp    (rsp)
   );

   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !emit_busy)
      else $error("emitter busy while sequencer idle");

   a_restart: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req.action) |=>
         (cur_clock_ff == CLOCK_INVALID) && (expected_ff == '0) && (offset_ff == '0))
      else $error("restart did not clear the timeline");

endmodule
`default_nettype wire

/* tb/sv/tb.sv */
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pnes_pkg::*;

   localparam int POS_W        = 48;
   localparam int MAX_EV       = 64;
   localparam int SETTLE_CYC   = 80;      // quiet wait that rides out a silent divide
   localparam int END_CYC      = 120;
   localparam int HOLD_AT      = 150;     // accepted items before the long rsp hold
   localparam int HOLD_CYC     = 400;
   localparam int CYCLE_LIMIT  = 1500000;
   localparam int PHASES       = 6;
   localparam int PHASE_ITEMS  = 85;

   localparam logic ACT_CYCLE   = 1'b0;
   localparam logic ACT_RESTART = 1'b1;

   typedef enum logic [1:0] {OP_CYCLE, OP_SET_PERIOD, OP_QUIESCE} op_kind_type;

   typedef struct packed {
      logic              action;
      logic [ID_W-1:0]   timebase_id;
      logic [CPOS_W-1:0] clock_position;
      logic [DUR_W-1:0]  cycle_duration;
   } cycle_item_type;

   typedef struct packed {
      logic [OFS_W-1:0]  event_offset;
      logic              note_on;
      logic [WORD_W-1:0] event_word;
      logic              last_event;
      logic              events_dropped;
   } note_event_type;

   typedef struct {
      op_kind_type         kind;
      cycle_item_type      item;
      logic [PERIOD_W-1:0] period;
   } pending_op_type;

   // ------------------------------------------------------------------
   // clock, reset and the block's inputs (all known from time zero)
   // ------------------------------------------------------------------
   logic                clock;
   logic                reset      = 1'b1;
   logic                req_valid  = 1'b0;
   cycle_item_type      req_item   = '0;
   logic                csr_valid  = 1'b0;
   logic [PERIOD_W-1:0] csr_period = '0;
   logic                rsp_ready  = 1'b0;
   logic                rsp_hold   = 1'b0;

   pnes_req_if req_ch ();
   pnes_rsp_if rsp_ch ();
   pnes_csr_if csr_ch ();

   assign req_ch.valid          = req_valid;
   assign req_ch.action         = req_item.action;
   assign req_ch.timebase_id    = req_item.timebase_id;
   assign req_ch.clock_position = req_item.clock_position;
   assign req_ch.cycle_duration = req_item.cycle_duration;
   assign csr_ch.valid          = csr_valid;
   assign csr_ch.period_samples = csr_period;
   assign rsp_ch.ready          = rsp_ready;

   periodic_note_event_scheduler_top #(
      .MAX_EVENTS    (MAX_EV),
      .POSITION_BITS (POS_W)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // shadow of the scheduler: period, clock id, timeline offset, resume
   // ------------------------------------------------------------------
   logic [PERIOD_W-1:0] period_q = PERIOD_RESET;
   logic [ID_W-1:0]     clock_q  = CLOCK_INVALID;
   logic [POS_W-1:0]    base_q   = '0;   // clock position minus local position
   logic [POS_W-1:0]    resume_q = '0;   // local position the next cycle should start at

   note_event_type  due_events[$];
   pending_op_type  pending_ops[$];
   int              n_errors   = 0;
   int              n_accepted = 0;
   int              n_events   = 0;
   int              cycle_cnt  = 0;

   task automatic flag_error(input string msg);
      if (n_errors < 100)
         $display("ERROR @%0t: %s", $time, msg);
      n_errors++;
   endtask

   // Work out the events one accepted item causes and queue them up.
   task automatic schedule_events(input cycle_item_type it);
      logic [DUR_W-1:0] dur;
      logic [POS_W-1:0] local_pos;
      logic [63:0]      p, sp, r, off, idx, total, emit;
      logic             parity;
      note_event_type   ev;
      if (it.action == ACT_RESTART) begin
         clock_q  = CLOCK_INVALID;
         base_q   = '0;
         resume_q = '0;
      end else begin
         // long cycles saturate, zero period behaves as one
         dur = (it.cycle_duration > DURATION_MAX) ? DURATION_MAX : it.cycle_duration;
         p   = (period_q == '0) ? 64'd1 : 64'(period_q);
         // new clock: re-base so the local timeline carries on
         if (clock_q != it.timebase_id) begin
            base_q  = it.clock_position - resume_q;
            clock_q = it.timebase_id;
         end
         local_pos = it.clock_position - base_q;
         resume_q  = local_pos + POS_W'(dur);
         sp        = 64'(local_pos);
         r         = sp % p;
         off       = (r != 0) ? p - r : 64'd0;
         idx       = sp / p + ((r != 0) ? 64'd1 : 64'd0);
         parity    = idx[0];
         if (off < 64'(dur)) begin
            total = (64'(dur) - 64'd1 - off) / p + 64'd1;
            emit  = (total > MAX_EV) ? 64'(MAX_EV) : total;
            for (int k = 0; k < emit; k++) begin
               ev.event_offset   = off[OFS_W-1:0];
               ev.note_on        = !parity;
               ev.event_word     = parity ? WORD_NOTE_OFF : WORD_NOTE_ON;
               ev.last_event     = (k + 1 == emit);
               ev.events_dropped = (k + 1 == emit) && (total > emit);
               due_events.push_back(ev);
               off    = off + p;
               parity = !parity;
            end
         end
      end
   endtask

   task automatic queue_cycle(input logic act, input logic [ID_W-1:0] id,
                              input logic [CPOS_W-1:0] pos, input logic [DUR_W-1:0] dur);
      pending_op_type op;
      op.kind   = OP_CYCLE;
      op.item   = '{action: act, timebase_id: id, clock_position: pos, cycle_duration: dur};
      op.period = '0;
      pending_ops.push_back(op);
   endtask

   // a period write always goes behind a full drain of the block
   task automatic queue_period(input logic [PERIOD_W-1:0] value);
      pending_op_type op;
      op.kind   = OP_QUIESCE;
      op.item   = '0;
      op.period = '0;
      pending_ops.push_back(op);
      op.kind   = OP_SET_PERIOD;
      op.period = value;
      pending_ops.push_back(op);
   endtask

   function automatic logic [CPOS_W-1:0] rand_pos();
      return {16'($urandom_range(0, 16'hFFFF)), 32'($urandom)};
   endfunction

   // mostly short cycles, some full ones, a few anywhere in the field
   function automatic logic [DUR_W-1:0] rand_dur();
      case ($urandom_range(0, 9))
         0:       return DURATION_MAX;
         1:       return DUR_W'($urandom_range(0, 16383));
         2:       return DUR_W'($urandom_range(1000, 8192));
         default: return DUR_W'($urandom_range(1, 600));
      endcase
   endfunction

   function automatic logic [PERIOD_W-1:0] phase_period(input int ph);
      case (ph)
         0:       return PERIOD_W'($urandom_range(2, 16));
         1:       return PERIOD_W'($urandom_range(17, 400));
         2:       return '0;
         3:       return PERIOD_W'($urandom_range(1000, 9000));
         4:       return PERIOD_W'($urandom_range(8193, 24'hFFFFFF));
         default: return PERIOD_W'(1);
      endcase
   endfunction

   // ------------------------------------------------------------------
   // sender: bursts of items with random gaps, drains before csr writes
   // ------------------------------------------------------------------
   int burst_left = 0;
   int gap_left   = 0;
   int settle_cnt = 0;

   always @(posedge clock) begin : sender
      logic           busy;
      logic           offer_req;
      logic           offer_csr;
      pending_op_type op;
      if (reset) begin
         req_valid  <= 1'b0;
         csr_valid  <= 1'b0;
         burst_left = $urandom_range(1, 24);
         gap_left   = 0;
         settle_cnt = 0;
      end else begin
         busy = (req_valid && !req_ch.ready) || (csr_valid && !csr_ch.ready);
         // predict on the transfer itself
         if (req_valid && req_ch.ready) begin
            schedule_events(req_item);
            n_accepted <= n_accepted + 1;
         end
         if (csr_valid && csr_ch.ready)
            period_q = csr_period;
         if (!busy) begin
            offer_req = 1'b0;
            offer_csr = 1'b0;
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_ops.size() != 0) begin
               op = pending_ops[0];
               case (op.kind)
                  OP_QUIESCE: begin
                     // all events in, then ride out a possibly silent divide
                     if (due_events.size() == 0) begin
                        if (settle_cnt >= SETTLE_CYC) begin
                           settle_cnt = 0;
                           void'(pending_ops.pop_front());
                        end else begin
                           settle_cnt++;
                        end
                     end else begin
                        settle_cnt = 0;
                     end
                  end
                  OP_SET_PERIOD: begin
                     csr_period <= op.period;
                     offer_csr = 1'b1;
                     void'(pending_ops.pop_front());
                  end
                  default: begin
                     req_item <= op.item;
                     offer_req = 1'b1;
                     void'(pending_ops.pop_front());
                     burst_left--;
                     if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 24);
                        case ($urandom_range(0, 3))
                           0:       gap_left = 0;
                           1:       gap_left = $urandom_range(1, 3);
                           2:       gap_left = $urandom_range(4, 15);
                           default: gap_left = $urandom_range(16, 60);
                        endcase
                     end
                  end
               endcase
            end
            req_valid <= offer_req;
            csr_valid <= offer_csr;
         end
      end
   end

   // ------------------------------------------------------------------
   // receiver: stall pattern in modes (none / light / heavy)
   // ------------------------------------------------------------------
   int rx_mode    = 0;
   int mode_left  = 0;
   int stall_left = 0;

   always @(posedge clock) begin : receiver
      if (reset) begin
         rsp_ready  <= 1'b0;
         mode_left  = 0;
         stall_left = 0;
      end else begin
         if (mode_left == 0) begin
            rx_mode   = $urandom_range(0, 2);
            mode_left = $urandom_range(50, 400);
         end else begin
            mode_left--;
         end
         if (stall_left > 0) begin
            stall_left--;
         end else begin
            case (rx_mode)
               1:       if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 3);
               2:       if ($urandom_range(0, 1) == 0) stall_left = $urandom_range(1, 8);
               default: ;
            endcase
         end
         rsp_ready <= !(rsp_hold || stall_left > 0);
      end
   end

   // one long rsp hold-off mid-run so the block backs up into req
   int  hold_cnt  = 0;
   logic hold_done = 1'b0;

   always @(posedge clock) begin : long_hold
      if (reset) begin
         rsp_hold  <= 1'b0;
         hold_done <= 1'b0;
         hold_cnt  <= 0;
      end else if (!hold_done && !rsp_hold && n_accepted >= HOLD_AT) begin
         rsp_hold <= 1'b1;
         hold_cnt <= 0;
      end else if (rsp_hold) begin
         hold_cnt <= hold_cnt + 1;
         if (hold_cnt == HOLD_CYC - 1) begin
            rsp_hold  <= 1'b0;
            hold_done <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------
   // monitor: each event transfer against the oldest queued event
   // ------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      note_event_type got;
      note_event_type want;
      if (!reset && rsp_ch.valid && rsp_ready) begin
         got.event_offset   = rsp_ch.event_offset;
         got.note_on        = rsp_ch.note_on;
         got.event_word     = rsp_ch.event_word;
         got.last_event     = rsp_ch.last_event;
         got.events_dropped = rsp_ch.events_dropped;
         if (due_events.size() == 0) begin
            flag_error($sformatf("event %0d arrived with none due (offset %0d)",
                                 n_events, got.event_offset));
         end else begin
            want = due_events.pop_front();
            if (got.event_offset !== want.event_offset)
               flag_error($sformatf("event %0d event_offset %0d, want %0d",
                                    n_events, got.event_offset, want.event_offset));
            if (got.note_on !== want.note_on)
               flag_error($sformatf("event %0d note_on %b, want %b",
                                    n_events, got.note_on, want.note_on));
            if (got.event_word !== want.event_word)
               flag_error($sformatf("event %0d event_word %h, want %h",
                                    n_events, got.event_word, want.event_word));
            if (got.last_event !== want.last_event)
               flag_error($sformatf("event %0d last_event %b, want %b",
                                    n_events, got.last_event, want.last_event));
            if (got.events_dropped !== want.events_dropped)
               flag_error($sformatf("event %0d events_dropped %b, want %b",
                                    n_events, got.events_dropped, want.events_dropped));
         end
         n_events <= n_events + 1;
      end
   end

   // hard stop if the block hangs
   always @(posedge clock) begin : watchdog
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt == CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // stimulus plan and end of run
   // ------------------------------------------------------------------
   initial begin : stimulus
      logic [ID_W-1:0]   stream_id;
      logic [CPOS_W-1:0] stream_pos;
      logic [DUR_W-1:0]  dur;
      int                sel;

      // directed, reset period (6000)
      queue_cycle(ACT_CYCLE, 32'h5, 48'h0, DURATION_MAX);             // first clock, rebase
      queue_cycle(ACT_CYCLE, 32'h5, 48'h2000, DURATION_MAX);          // same clock, continuous
      queue_cycle(ACT_CYCLE, 32'h7, 48'hFFFF_FFFF_F000, DURATION_MAX); // clock change
      queue_cycle(ACT_CYCLE, 32'h7, 48'h0000_0000_1000, DURATION_MAX); // clock position wraps
      queue_cycle(ACT_RESTART, CLOCK_INVALID, 48'hFFFF_FFFF_FFFF, 14'h3FFF);
      // invalid id after restart: no rebase, local position = clock position
      queue_cycle(ACT_CYCLE, CLOCK_INVALID, 48'hFFFF_FFFF_FFFF, 14'h3FFF); // saturated length
      queue_cycle(ACT_CYCLE, CLOCK_INVALID, 48'h0, 14'd0);            // zero length
      queue_cycle(ACT_CYCLE, CLOCK_INVALID, 48'h0, 14'd1);
      queue_cycle(ACT_CYCLE, 32'h0, 48'h1234_5678_9ABC, DURATION_MAX);

      // period 1: overflow past the event cap
      queue_period(24'd1);
      queue_cycle(ACT_CYCLE, 32'h0, 48'h1234_5678_BABC, DURATION_MAX);
      queue_cycle(ACT_CYCLE, 32'h0, 48'h1234_5678_DABC, 14'd64);      // exactly at the cap
      queue_cycle(ACT_CYCLE, 32'h0, 48'h1234_5678_DAFC, 14'd65);      // one over

      // zero period behaves as one
      queue_period(24'd0);
      queue_cycle(ACT_CYCLE, 32'h0, 48'h0, 14'd100);
      queue_cycle(ACT_CYCLE, 32'h0, 48'h64, 14'd3);

      // widest period
      queue_period(24'hFF_FFFF);
      queue_cycle(ACT_RESTART, 32'h0, 48'h0, 14'd0);
      queue_cycle(ACT_CYCLE, CLOCK_INVALID, CPOS_W'(3 * 64'hFF_FFFF - 100), DURATION_MAX);
      queue_cycle(ACT_CYCLE, CLOCK_INVALID, 48'hFFFF_FFFF_FFCD, DURATION_MAX);

      // small period across the 48-bit wrap
      queue_period(24'd7);
      queue_cycle(ACT_CYCLE, CLOCK_INVALID, 48'hFFFF_FFFF_FFF6, 14'd30);
      queue_cycle(ACT_CYCLE, 32'hFFFF_FFFE, rand_pos(), 14'd8191);

      queue_period(PERIOD_RESET);

      // random phases: mostly continuous streams, some switches, restarts, noise
      for (int ph = 0; ph < PHASES; ph++) begin
         if (ph != 0)
            queue_period(phase_period(ph));
         stream_id  = $urandom;
         stream_pos = rand_pos();
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            sel = $urandom_range(0, 99);
            if (sel < 5) begin
               queue_cycle(ACT_RESTART, ID_W'($urandom), rand_pos(), DUR_W'($urandom));
            end else if (sel < 15) begin
               queue_cycle(ACT_CYCLE, ($urandom_range(0, 1) != 0) ? stream_id : ID_W'($urandom),
                           rand_pos(), DUR_W'($urandom_range(0, 16383)));
            end else begin
               if (sel < 22) begin
                  stream_id  = ($urandom_range(0, 3) == 0) ? CLOCK_INVALID : ID_W'($urandom);
                  stream_pos = rand_pos();
               end
               dur = rand_dur();
               queue_cycle(ACT_CYCLE, stream_id, stream_pos, dur);
               stream_pos = stream_pos + CPOS_W'(dur);
            end
         end
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // everything offered and taken, then everything back, then a quiet tail
      while (pending_ops.size() != 0 || req_valid || csr_valid)
         @(posedge clock);
      while (due_events.size() != 0)
         @(posedge clock);
      repeat (END_CYC) @(posedge clock);

      if (due_events.size() != 0)
         flag_error($sformatf("%0d events never arrived", due_events.size()));
      if (n_errors == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

/* sim.f */
design/pnes_pkg.sv
design/pnes_if.sv
design/pnes_divider.sv
design/pnes_emitter.sv
design/periodic_note_event_scheduler_top.sv
tb/sv/tb.sv
